FILE: hdl/wbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wbp_pkg;

    typedef enum logic [2:0] {
        FN_RESTART = 3'd0,
        FN_WRITE   = 3'd1,
        FN_READ    = 3'd2,
        FN_LOAD    = 3'd3,
        FN_FETCH   = 3'd4
    } t_func;

    localparam int          CFG_IDX_W  = 1;
    localparam int          CFG_DATA_W = 16;
    localparam logic [0:0]  CFG_BPS    = 1'b0;
    localparam logic [0:0]  CFG_SEED   = 1'b1;

    localparam logic [3:0]  BPS_RESET  = 4'd5;
    localparam logic [15:0] SEED_RESET = 16'd0;

    // floor(r / 71) == (r * 59075) >> 22 for every 16-bit r
    localparam logic [15:0] WH_RECIP   = 16'd59075;
    localparam int          WH_SHIFT   = 22;
    localparam logic [15:0] WH_BIAS    = 16'd3;

    typedef struct packed {
        logic div_start;
        logic div_step;
        logic capture;
        logic wh_a;
        logic wh_b;
        logic issue;
        logic mem_op;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic bps_wr;
        logic in_field;
        logic div_last;
        logic w_zero;
        logic last_bit;
        logic out_free;
    } t_sts;

    function automatic logic [15:0] width_mask(input logic [4:0] w);
        logic [15:0] m;
        for (int j = 0; j < 16; j++) begin
            m[j] = (5'(j) < w);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/wbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wbp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wbp_pkg::t_sts      i_sts,
    output wbp_pkg::t_cmd      o_cmd
);
    import wbp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIV   = 8'b0000_0010,
        S_WHA   = 8'b0000_0100,
        S_WHB   = 8'b0000_1000,
        S_BITS  = 8'b0001_0000,
        S_FLUSH = 8'b0010_0000,
        S_MEM   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_sts.bps_wr;
                if (i_sts.bps_wr) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_sts.in_field ? S_WHA : S_MEM;
                end
            end
            S_DIV: begin
                if (i_sts.bps_wr) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.div_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WHA: begin
                o_cmd.wh_a = 1'b1;
                n_state    = S_WHB;
            end
            S_WHB: begin
                o_cmd.wh_b = 1'b1;
                n_state    = i_sts.w_zero ? S_FIN : S_BITS;
            end
            S_BITS: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_bit) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_FIN;
            end
            S_MEM: begin
                o_cmd.mem_op = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/wbp_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module wbp_dpath #(
    parameter int SYMBOLS        = 32,
    parameter int MAX_FIELD_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wbp_pkg::t_cmd                       i_cmd,
    output wbp_pkg::t_sts                       o_sts,
    input  wire logic                           i_cfg_we,
    input  wire logic [wbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wbp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [2:0]                     i_func,
    input  wire logic [15:0]                    i_field_value,
    input  wire logic [4:0]                     i_field_width,
    input  wire logic [4:0]                     i_symbol_index,
    input  wire logic [7:0]                     i_symbol_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [15:0]                         o_read_value,
    output logic [7:0]                          o_symbol_out,
    output logic [8:0]                          o_bit_position,
    output logic                                o_overflow
);
    import wbp_pkg::*;

    localparam int AW = $clog2(SYMBOLS);
    localparam int FW = MAX_FIELD_BITS;
    localparam int IW = (FW > 1) ? $clog2(FW) : 1;

    logic [3:0]    r_bps;
    logic [15:0]   r_seed;
    logic [15:0]   r_rn;
    logic [8:0]    r_p;
    logic [8:0]    r_slot;
    logic [3:0]    r_off;
    logic [8:0]    r_dsh;
    logic [3:0]    r_dcnt;

    t_func         r_func;
    logic [FW-1:0] r_fval;
    logic [4:0]    r_w;
    logic [4:0]    r_sidx;
    logic [7:0]    r_sin;
    logic [FW-1:0] r_v;
    logic          r_ovf;
    logic          r_fetch_ok;

    logic [15:0]   r_wr;
    logic [31:0]   r_prod;

    logic [IW-1:0] r_i;
    logic [4:0]    r_left;

    logic          r_s2_v;
    logic [AW-1:0] r_s2_slot;
    logic [2:0]    r_s2_off;
    logic          r_s2_bit;
    logic [IW-1:0] r_s2_i;

    logic [7:0]    r_mem [SYMBOLS];
    logic [SYMBOLS-1:0] r_vld;
    logic [7:0]    r_rdata;
    logic          r_rvld;

    logic          r_lw_v;
    logic [AW-1:0] r_lw_slot;
    logic [7:0]    r_lw_byte;

    logic          r_ov;
    logic [15:0]   r_o_rd;
    logic [7:0]    r_o_sout;
    logic [8:0]    r_o_pos;
    logic          r_o_ovf;

    logic [3:0]    b_eff;
    logic [4:0]    dv_t;
    logic          dv_ge;
    logic [3:0]    dv_rem;
    logic [4:0]    w_clamp;
    logic          in_rng;
    logic          adv;
    logic [3:0]    off_inc;
    logic          off_wrap;
    logic [6:0]    sidx_x;
    logic          sidx_ok;
    logic [15:0]   t17;
    logic [15:0]   wr_n;
    logic [31:0]   prod_n;
    logic [15:0]   rn_n;
    logic [7:0]    s2_base;
    logic [7:0]    s2_byte;
    logic [7:0]    s2_new;
    logic          is_wr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mask16;
    logic [15:0]   res_rd;
    logic          restart_now;

    assign b_eff    = (r_bps == 4'd0) ? 4'd1 : r_bps;
    assign dv_t     = {r_off, r_dsh[8]};
    assign dv_ge    = dv_t >= {1'b0, b_eff};
    assign dv_rem   = dv_ge ? 4'(dv_t - {1'b0, b_eff}) : dv_t[3:0];

    assign w_clamp  = (i_field_width > 5'(MAX_FIELD_BITS)) ? 5'(MAX_FIELD_BITS)
                                                          : i_field_width;
    assign in_rng   = !r_p[8] && (r_slot < 9'(SYMBOLS));
    assign adv      = !r_p[8];
    assign off_inc  = r_off + 4'd1;
    assign off_wrap = (off_inc == b_eff);

    assign sidx_x   = 7'(r_sidx);
    assign sidx_ok  = sidx_x < 7'(SYMBOLS);

    assign t17      = r_rn + {r_rn[11:0], 4'b0000};
    assign wr_n     = {t17[12:0], 3'b000};
    assign prod_n   = 32'(wr_n) * 32'(WH_RECIP);
    assign rn_n     = r_wr + 16'(r_prod[31:WH_SHIFT]) + WH_BIAS;

    assign is_wr    = (r_func == FN_WRITE);
    assign s2_base  = r_rvld ? r_rdata : 8'd0;
    assign s2_byte  = (r_lw_v && (r_lw_slot == r_s2_slot)) ? r_lw_byte : s2_base;
    assign s2_new   = s2_byte | (8'(r_s2_bit) << r_s2_off);

    assign restart_now = i_cmd.mem_op && (r_func == FN_RESTART);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_s2_slot;
        mem_wdata = s2_new;
        if (r_s2_v && is_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.mem_op && (r_func == FN_LOAD) && sidx_ok) begin
            mem_we    = 1'b1;
            mem_waddr = sidx_x[AW-1:0];
            mem_wdata = r_sin;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_slot[AW-1:0];
        if (i_cmd.issue && in_rng) begin
            mem_re = 1'b1;
        end else if (i_cmd.mem_op && (r_func == FN_FETCH) && sidx_ok) begin
            mem_re    = 1'b1;
            mem_raddr = sidx_x[AW-1:0];
        end
    end

    assign mask16 = width_mask(r_w);
    assign res_rd = (r_func == FN_READ) ? ((16'(r_v) - r_rn) & mask16) : 16'd0;

    always_comb begin
        o_sts          = '0;
        o_sts.bps_wr   = i_cfg_we && (i_cfg_idx == CFG_BPS);
        o_sts.in_field = (i_func == FN_WRITE) || (i_func == FN_READ);
        o_sts.div_last = (r_dcnt == 4'd0);
        o_sts.w_zero   = (r_w == 5'd0);
        o_sts.last_bit = (r_left == 5'd1);
        o_sts.out_free = !r_ov || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps  <= BPS_RESET;
            r_seed <= SEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BPS:  r_bps  <= i_cfg_wdata[3:0];
                CFG_SEED: r_seed <= i_cfg_wdata;
                default:  r_bps  <= r_bps;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p    <= '0;
            r_slot <= '0;
            r_off  <= '0;
        end else if (i_cmd.div_start) begin
            r_slot <= '0;
            r_off  <= '0;
        end else if (i_cmd.div_step) begin
            r_slot <= {r_slot[7:0], dv_ge};
            r_off  <= dv_rem;
        end else if (i_cmd.issue && adv) begin
            r_p <= r_p + 9'd1;
            if (off_wrap) begin
                r_off  <= 4'd0;
                r_slot <= r_slot + 9'd1;
            end else begin
                r_off <= off_inc;
            end
        end else if (restart_now) begin
            r_p    <= '0;
            r_slot <= '0;
            r_off  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dsh  <= r_p;
            r_dcnt <= 4'd8;
        end else if (i_cmd.div_step) begin
            r_dsh  <= {r_dsh[7:0], 1'b0};
            r_dcnt <= r_dcnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rn <= '0;
        end else if (i_cmd.wh_b) begin
            r_rn <= rn_n;
        end else if (restart_now) begin
            r_rn <= r_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wh_a) begin
            r_wr   <= wr_n;
            r_prod <= prod_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= t_func'(i_func);
            r_fval     <= i_field_value[FW-1:0];
            r_w        <= w_clamp;
            r_sidx     <= i_symbol_index;
            r_sin      <= i_symbol_in;
            r_v        <= '0;
            r_ovf      <= 1'b0;
            r_fetch_ok <= 1'b0;
        end else begin
            if (i_cmd.wh_b && is_wr) begin
                r_v <= r_fval + rn_n[FW-1:0];
            end else if (r_s2_v && !is_wr) begin
                r_v[r_s2_i] <= s2_byte[r_s2_off];
            end
            if (i_cmd.issue && !in_rng) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.mem_op && ((r_func == FN_LOAD) || (r_func == FN_FETCH))) begin
                r_ovf      <= !sidx_ok;
                r_fetch_ok <= (r_func == FN_FETCH) && sidx_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wh_b) begin
            r_i    <= '0;
            r_left <= r_w;
        end else if (i_cmd.issue) begin
            r_i    <= r_i + IW'(1);
            r_left <= r_left - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_lw_v <= 1'b0;
        end else begin
            r_s2_v <= i_cmd.issue && in_rng;
            if (i_cmd.capture) begin
                r_lw_v <= 1'b0;
            end else if (r_s2_v && is_wr) begin
                r_lw_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s2_slot <= r_slot[AW-1:0];
            r_s2_off  <= r_off[2:0];
            r_s2_bit  <= r_v[r_i];
            r_s2_i    <= r_i;
        end
        if (r_s2_v && is_wr) begin
            r_lw_slot <= r_s2_slot;
            r_lw_byte <= s2_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (restart_now) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rvld <= r_vld[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_rd   <= res_rd;
            r_o_sout <= r_fetch_ok ? s2_base : 8'd0;
            r_o_pos  <= r_p;
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_read_value   = r_o_rd;
    assign o_symbol_out   = r_o_sout;
    assign o_bit_position = r_o_pos;
    assign o_overflow     = r_o_ovf;

endmodule

`default_nettype wire

FILE: hdl/whitened_bitfield_packer.sv
// Whitened bit-field packer.
// Input channel (i_in_valid / o_in_ready) takes one transaction: a function
// code with its field value, field width, symbol slot and symbol byte.
// Output channel (o_out_valid / i_out_ready) returns one transaction per input.
// Configuration: i_cfg_we writes register i_cfg_idx (0 bits per symbol,
// 1 whitening seed) in the same cycle, with no read-back.
// Steps per transaction, from accept to the next accept: a field write or read
// of width w runs the whitening steps, then one bit per cycle through the
// symbol store, then a step to retire the last bit and a hand-off step; at
// width zero it skips the bit and retire steps. Restart, load, fetch and
// unused codes go through a command step and the hand-off step.
// The result is registered: o_out_valid rises in the cycle after the hand-off
// step, and the core takes the next transaction while it waits.
// A stalled receiver holds the result; the core then waits in its hand-off
// step until the output register frees.
// Writing bits per symbol starts a bit-serial division that maps the bit
// counter onto slot and offset; o_in_ready stays low meanwhile.
// Reset (synchronous, active low) clears the store, the counter and the
// whitening state and loads the register defaults; it takes effect at once.
`timescale 1ns / 1ps
`default_nettype none

module whitened_bitfield_packer #(
    parameter int SYMBOLS        = 32,
    parameter int MAX_FIELD_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [wbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wbp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [2:0]                     i_func,
    input  wire logic [15:0]                    i_field_value,
    input  wire logic [4:0]                     i_field_width,
    input  wire logic [4:0]                     i_symbol_index,
    input  wire logic [7:0]                     i_symbol_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [15:0]                         o_read_value,
    output logic [7:0]                          o_symbol_out,
    output logic [8:0]                          o_bit_position,
    output logic                                o_overflow
);
    import wbp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    wbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wbp_dpath #(
        .SYMBOLS        (SYMBOLS),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_func),
        .i_field_value  (i_field_value),
        .i_field_width  (i_field_width),
        .i_symbol_index (i_symbol_index),
        .i_symbol_in    (i_symbol_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_value   (o_read_value),
        .o_symbol_out   (o_symbol_out),
        .o_bit_position (o_bit_position),
        .o_overflow     (o_overflow)
    );

endmodule

`default_nettype wire

FILE: hdl/wbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wbp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_read_value,
    input wire logic [7:0]  o_symbol_out,
    input wire logic [8:0]  o_bit_position
);

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid survived reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
            && $stable(o_symbol_out) && $stable(o_bit_position))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("core took a second transaction while busy");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_read_value == 16'd0 || o_symbol_out == 8'd0))
        else $error("read value and fetched symbol both set");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_bit_position <= 9'd256)
        else $error("bit position past saturation");

endmodule

bind whitened_bitfield_packer wbp_checker u_wbp_checker (.*);

`default_nettype wire
